// ===== hdl/cgrc_pkg.sv =====
package cgrc_pkg;

  // Configuration port geometry and register indexes.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_CODE_LIMIT        = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HALVING_THRESHOLD = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ESCAPE_BITS       = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_ERROR_SUM = 2'd3;

  // Register reset values.
  localparam logic [6:0] CODE_LIMIT_RESET        = 7'd32;
  localparam logic [7:0] HALVING_THRESHOLD_RESET = 8'd64;
  localparam logic [4:0] ESCAPE_BITS_RESET       = 5'd8;

  // Context statistics after reset.
  localparam logic [15:0] INIT_ERROR_SUM  = 16'd4;
  localparam logic [7:0]  INIT_OCCURRENCE = 8'd1;

  // Bias correction limits.
  localparam logic signed [7:0] CORR_MIN = -8'sd128;
  localparam logic signed [7:0] CORR_MAX = 8'sd127;

  // Largest Golomb parameter and largest escape width.
  localparam logic [4:0] K_MAX          = 5'd16;
  localparam logic [4:0] ESC_BITS_MAX   = 5'd16;

  // One context word as held in the statistics memory.
  typedef struct packed {
    logic [15:0] a;
    logic [9:0]  b;
    logic [7:0]  n;
    logic [7:0]  c;
  } ctx_word_t;

  localparam int CTX_WORD_W = $bits(ctx_word_t);

  // Request to and response from the iterative k search unit.
  typedef struct packed {
    logic        start;
    logic [7:0]  n;
    logic [16:0] a;
  } kunit_req_t;

  typedef struct packed {
    logic       done;
    logic [4:0] k;
  } kunit_rsp_t;

endpackage

// ===== hdl/cgrc_ram.sv =====
module cgrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/cgrc_kunit.sv =====
module cgrc_kunit (
  input  logic                clk,
  input  logic                rst,
  input  cgrc_pkg::kunit_req_t req,
  output cgrc_pkg::kunit_rsp_t rsp
);
  import cgrc_pkg::*;

  logic        busy;
  logic [23:0] nk;
  logic [16:0] a_lim;
  logic [4:0]  k;
  logic        step;

  // One shift and compare per cycle: keep doubling N while it is below A and k is below K_MAX.
  assign step = ({7'd0, a_lim} > nk) && (k < K_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
    end else if (busy && !step) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      nk    <= {16'd0, req.n};
      a_lim <= req.a;
      k     <= '0;
    end else if (busy && step) begin
      nk <= {nk[22:0], 1'b0};
      k  <= k + 5'd1;
    end
  end

  assign rsp.done = busy && !step;
  assign rsp.k    = k;

endmodule

// ===== hdl/cgrc_emit.sv =====
module cgrc_emit (
  input  logic              [8:0]  m,
  input  logic              [4:0]  k,
  input  logic signed       [7:0]  limit,
  input  logic              [4:0]  escape_bits,
  output logic              [6:0]  zero_count,
  output logic              [15:0] suffix_bits,
  output logic              [4:0]  suffix_length
);
  import cgrc_pkg::*;

  logic [8:0]  unary;
  logic        limit_pos;
  logic        golomb;
  logic [4:0]  q;
  logic [16:0] k_mask;
  logic [16:0] q_mask;
  logic [16:0] m_ext;
  logic [16:0] m_dec;
  logic [16:0] code;

  // Limited-length Golomb code, falling back to an escape codeword.
  always_comb begin
    unary     = m >> k;
    limit_pos = (limit > 8'sd0);
    golomb    = limit_pos && (unary < {2'b00, limit[6:0]});

    if (escape_bits == 5'd0) begin
      q = 5'd1;
    end else if (escape_bits > ESC_BITS_MAX) begin
      q = ESC_BITS_MAX;
    end else begin
      q = escape_bits;
    end

    k_mask = (17'd1 << k) - 17'd1;
    q_mask = (17'd1 << q) - 17'd1;
    m_ext  = {8'd0, m};
    m_dec  = m_ext - 17'd1;

    if (golomb) begin
      code          = (17'd1 << k) | (m_ext & k_mask);
      zero_count    = unary[6:0];
      suffix_length = k + 5'd1;
    end else begin
      code          = (17'd1 << q) | (m_dec & q_mask);
      zero_count    = limit_pos ? limit[6:0] : 7'd0;
      suffix_length = q + 5'd1;
    end

    // A seventeen-bit suffix loses its leading one here.
    suffix_bits = code[15:0];
  end

endmodule

// ===== hdl/context_golomb_residual_coder.sv =====
// Each item goes through the read, k search, map, halve, bias and emit steps to out_valid; no new
// item is taken until emit is left; the k search doubles N once a cycle to find Golomb k (0..16).
// Every item does a read, a k search and one write-back of its context word in one memory.
// After reset a clearing pass writes the initial statistics to all REGULAR_CONTEXTS + 2 context
// words (367 by default); in_stall stays high meanwhile, configuration writes are still taken.
module context_golomb_residual_coder #(
  parameter int REGULAR_CONTEXTS = 365
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 command,
  input  logic [8:0]                           context_index,
  input  logic                                 sign_negative,
  input  logic [7:0]                           prediction,
  input  logic [7:0]                           sample_value,
  input  logic [7:0]                           left_neighbour,
  input  logic [7:0]                           upper_neighbour,
  input  logic                                 run_type,
  input  logic [4:0]                           limit_reduction,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [6:0]                           zero_count,
  output logic [15:0]                          suffix_bits,
  output logic [4:0]                           suffix_length,
  input  logic                                 cfg_write_enable,
  input  logic [cgrc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [cgrc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import cgrc_pkg::*;

  localparam int DEPTH = REGULAR_CONTEXTS + 2;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [8:0]    LAST_REGULAR = 9'(REGULAR_CONTEXTS - 1);
  localparam logic [AW-1:0] RUN_BASE     = AW'(REGULAR_CONTEXTS);
  localparam logic [AW-1:0] LAST_ADDR    = AW'(DEPTH - 1);

  localparam logic [2:0] ST_CLEAR   = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_READ    = 3'd2;
  localparam logic [2:0] ST_KSEARCH = 3'd3;
  localparam logic [2:0] ST_MAP     = 3'd4;
  localparam logic [2:0] ST_HALVE   = 3'd5;
  localparam logic [2:0] ST_BIAS    = 3'd6;
  localparam logic [2:0] ST_EMIT    = 3'd7;

  logic [2:0]    state;
  logic [AW-1:0] clr_addr;

  // Configuration registers.
  logic [6:0] code_limit;
  logic [7:0] halving_threshold;
  logic [4:0] escape_bits;

  // Latched item.
  logic          it_cmd;
  logic          it_sign;
  logic [7:0]    it_pred;
  logic [7:0]    it_sample;
  logic [7:0]    it_ra;
  logic [7:0]    it_rb;
  logic          it_rt;
  logic [4:0]    it_red;
  logic [AW-1:0] addr_q;

  // Working copy of the context and intermediate results.
  logic [15:0]        ctx_a;
  logic signed [11:0] ctx_b;
  logic [7:0]         ctx_n;
  logic signed [7:0]  ctx_c;
  logic signed [7:0]  err_e;
  logic [4:0]         k_val;
  logic [8:0]         m_val;

  // Memory port signals.
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [CTX_WORD_W-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [CTX_WORD_W-1:0] ram_rdata;
  ctx_word_t             rd;
  ctx_word_t             wr_word;

  logic [8:0]  ctx_sat;
  kunit_req_t  k_req;
  kunit_rsp_t  k_rsp;
  logic        out_load;

  assign in_stall = (state != ST_IDLE);
  assign out_load = (state == ST_EMIT) && (!out_valid || !out_stall);

  // Configuration writes; the initial error sum index is accepted but ignored by the block.
  always_ff @(posedge clk) begin
    if (rst) begin
      code_limit        <= CODE_LIMIT_RESET;
      halving_threshold <= HALVING_THRESHOLD_RESET;
      escape_bits       <= ESCAPE_BITS_RESET;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        CFG_CODE_LIMIT:        code_limit        <= cfg_data[6:0];
        CFG_HALVING_THRESHOLD: halving_threshold <= cfg_data[7:0];
        CFG_ESCAPE_BITS:       escape_bits       <= cfg_data[4:0];
        CFG_INITIAL_ERROR_SUM: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Context address straight from the input ports, so the read overlaps the accept.
  assign ctx_sat   = (context_index > LAST_REGULAR) ? LAST_REGULAR : context_index;
  assign ram_raddr = command ? (RUN_BASE + AW'(run_type)) : AW'(ctx_sat);
  assign rd        = ctx_word_t'(ram_rdata);

  // Bias-corrected prediction and error, formed while the context word arrives.
  logic signed [9:0] corr;
  logic signed [9:0] px_corr;
  logic [7:0]        px_clamp;
  logic signed [9:0] diff;

  always_comb begin
    corr = {{2{rd.c[7]}}, rd.c};
    if (it_sign) begin
      corr = -corr;
    end
    px_corr = $signed({2'b00, it_pred}) + corr;
    if (px_corr < 10'sd0) begin
      px_clamp = 8'd0;
    end else if (px_corr > 10'sd255) begin
      px_clamp = 8'd255;
    end else begin
      px_clamp = px_corr[7:0];
    end

    if (it_cmd) begin
      diff = $signed({2'b00, it_sample}) - $signed({2'b00, it_rb});
      if (!it_rt && (it_rb < it_ra)) begin
        diff = -diff;
      end
    end else if (it_sign) begin
      diff = $signed({2'b00, px_clamp}) - $signed({2'b00, it_sample});
    end else begin
      diff = $signed({2'b00, it_sample}) - $signed({2'b00, px_clamp});
    end
  end

  // The k search starts as soon as the context word is read.
  assign k_req.start = (state == ST_READ);
  assign k_req.n     = rd.n;
  assign k_req.a     = {1'b0, rd.a} + ((it_cmd && it_rt) ? {10'd0, rd.n[7:1]} : 17'd0);

  cgrc_kunit u_kunit (
    .clk (clk),
    .rst (rst),
    .req (k_req),
    .rsp (k_rsp)
  );

  // Error mapping and the first statistics update.
  logic signed [8:0]  e9;
  logic [8:0]         mag;
  logic signed [12:0] twob;
  logic signed [12:0] n13;
  logic               k_zero;
  logic               flip;
  logic               extra;
  logic [9:0]         m_reg10;
  logic signed [10:0] m_run_s;
  logic [8:0]         m_run;
  logic [9:0]         run_add10;
  logic [8:0]         mag_add;
  logic [16:0]        a_sum;
  logic [15:0]        a_sat;
  logic signed [11:0] b_map;
  logic [8:0]         m_new;

  always_comb begin
    e9     = {err_e[7], err_e};
    mag    = err_e[7] ? 9'(-e9) : 9'(e9);
    twob   = {ctx_b, 1'b0};
    n13    = $signed({5'd0, ctx_n});
    k_zero = (k_val == 5'd0);
    flip   = k_zero && (twob <= -n13);
    extra  = k_zero && (err_e != 8'sd0) && (twob < n13);

    if (err_e[7]) begin
      m_reg10 = {mag, 1'b0} - 10'd1 - {9'd0, flip};
      m_run_s = $signed({1'b0, mag, 1'b0}) - 11'sd1 - $signed({10'd0, it_rt})
                + $signed({10'd0, extra});
    end else begin
      m_reg10 = {mag, 1'b0} + {9'd0, flip};
      m_run_s = $signed({1'b0, mag, 1'b0}) - $signed({10'd0, it_rt})
                - $signed({10'd0, extra});
    end
    m_run     = (m_run_s < 11'sd0) ? 9'd0 : m_run_s[8:0];
    run_add10 = {1'b0, m_run} + 10'd1 - {9'd0, it_rt};
    mag_add   = it_cmd ? run_add10[9:1] : mag;

    a_sum = {1'b0, ctx_a} + {8'd0, mag_add};
    a_sat = a_sum[16] ? 16'hFFFF : a_sum[15:0];

    if (it_cmd) begin
      b_map = err_e[7] ? (ctx_b + 12'sd1) : ctx_b;
    end else begin
      b_map = ctx_b + $signed({{4{err_e[7]}}, err_e});
    end
    m_new = it_cmd ? m_run : m_reg10[8:0];
  end

  // Bias correction update for regular contexts, after halving.
  logic signed [11:0] n12;
  logic signed [11:0] b_tmp;
  logic signed [11:0] b_next;
  logic signed [7:0]  c_next;

  always_comb begin
    n12    = $signed({4'd0, ctx_n});
    b_tmp  = ctx_b;
    b_next = ctx_b;
    c_next = ctx_c;
    if (!it_cmd) begin
      if (ctx_b <= -n12) begin
        if (ctx_c != CORR_MIN) begin
          c_next = ctx_c - 8'sd1;
        end
        b_tmp  = ctx_b + n12;
        b_next = (b_tmp <= -n12) ? (12'sd1 - n12) : b_tmp;
      end else if (ctx_b > 12'sd0) begin
        if (ctx_c != CORR_MAX) begin
          c_next = ctx_c + 8'sd1;
        end
        b_tmp  = ctx_b - n12;
        b_next = (b_tmp > 12'sd0) ? 12'sd0 : b_tmp;
      end
    end
  end

  // Memory write: initial words during the clearing pass, else the updated context.
  always_comb begin
    if (state == ST_CLEAR) begin
      wr_word.a = INIT_ERROR_SUM;
      wr_word.b = 10'd0;
      wr_word.n = INIT_OCCURRENCE;
      wr_word.c = 8'd0;
    end else begin
      wr_word.a = ctx_a;
      wr_word.b = b_next[9:0];
      wr_word.n = ctx_n;
      wr_word.c = c_next;
    end
  end

  assign ram_we    = (state == ST_CLEAR) || (state == ST_BIAS);
  assign ram_waddr = (state == ST_CLEAR) ? clr_addr : addr_q;
  assign ram_wdata = wr_word;

  cgrc_ram #(
    .WIDTH (CTX_WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          if (clr_addr == LAST_ADDR) begin
            state <= ST_IDLE;
          end else begin
            clr_addr <= clr_addr + AW'(1);
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_READ;
          end
        end
        ST_READ:    state <= ST_KSEARCH;
        ST_KSEARCH: begin
          if (k_rsp.done) begin
            state <= ST_MAP;
          end
        end
        ST_MAP:     state <= ST_HALVE;
        ST_HALVE:   state <= ST_BIAS;
        ST_BIAS:    state <= ST_EMIT;
        ST_EMIT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default:    state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers, loaded step by step as the sequencer advances.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          it_cmd    <= command;
          it_sign   <= sign_negative;
          it_pred   <= prediction;
          it_sample <= sample_value;
          it_ra     <= left_neighbour;
          it_rb     <= upper_neighbour;
          it_rt     <= run_type;
          it_red    <= limit_reduction;
          addr_q    <= ram_raddr;
        end
      end
      ST_READ: begin
        ctx_a <= rd.a;
        ctx_b <= {{2{rd.b[9]}}, rd.b};
        ctx_n <= rd.n;
        ctx_c <= rd.c;
        err_e <= diff[7:0];
      end
      ST_KSEARCH: begin
        k_val <= k_rsp.k;
      end
      ST_MAP: begin
        m_val <= m_new;
        ctx_a <= a_sat;
        ctx_b <= b_map;
      end
      ST_HALVE: begin
        if (ctx_n >= halving_threshold) begin
          ctx_n <= (ctx_n >> 1) + 8'd1;
          ctx_a <= ctx_a >> 1;
          ctx_b <= ctx_b >>> 1;
        end else begin
          ctx_n <= ctx_n + 8'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // Codeword formatting and the output register.
  logic signed [7:0] limit_s;
  logic [6:0]        zc_new;
  logic [15:0]       sb_new;
  logic [4:0]        sl_new;

  assign limit_s = $signed({1'b0, code_limit})
                   - (it_cmd ? $signed({3'b000, it_red}) : 8'sd0);

  cgrc_emit u_emit (
    .m             (m_val),
    .k             (k_val),
    .limit         (limit_s),
    .escape_bits   (escape_bits),
    .zero_count    (zc_new),
    .suffix_bits   (sb_new),
    .suffix_length (sl_new)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      zero_count    <= zc_new;
      suffix_bits   <= sb_new;
      suffix_length <= sl_new;
    end
  end

`ifndef NO_ASSERTIONS
  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_EMIT)
    else $error("result item raised outside the emit step");

  a_k_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_KSEARCH && k_rsp.done) |-> k_rsp.k <= K_MAX)
    else $error("Golomb parameter beyond its cap");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BIAS) |-> ctx_n != 8'd0)
    else $error("occurrence count written back as zero");

  a_bias_window: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BIAS && !it_cmd) |-> (b_next <= 12'sd0 && b_next > -n12))
    else $error("regular bias sum left outside its window");

  a_clear_exit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |=> (state == ST_CLEAR || state == ST_IDLE))
    else $error("clearing pass left for a working step");
`endif

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cgrc_pkg::*;

  localparam int REGULAR_CONTEXTS = 365;
  localparam int ALL_CONTEXTS = REGULAR_CONTEXTS + 2;

  // Pixel modes carried on the command input.
  localparam logic CMD_REGULAR = 1'b0;
  localparam logic CMD_RUN_INTERRUPTION = 1'b1;

  // k is at most 16, and this settling time covers any write-back still in flight.
  localparam int SETTLE_CYCLES = 32;
  localparam int REPORT_LIMIT = 30;

  typedef struct packed {
    logic       cmd;
    logic [8:0] ctx;
    logic       sign_neg;
    logic [7:0] pred;
    logic [7:0] pixel;
    logic [7:0] left_px;
    logic [7:0] upper_px;
    logic       rtype;
    logic [4:0] reduction;
  } pixel_t;

  typedef struct packed {
    logic [6:0]  zeros;
    logic [15:0] suffix;
    logic [4:0]  length;
  } codeword_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic command = 1'b0;
  logic [8:0] context_index = '0;
  logic sign_negative = 1'b0;
  logic [7:0] prediction = '0;
  logic [7:0] sample_value = '0;
  logic [7:0] left_neighbour = '0;
  logic [7:0] upper_neighbour = '0;
  logic run_type = 1'b0;
  logic [4:0] limit_reduction = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [6:0] zero_count;
  logic [15:0] suffix_bits;
  logic [4:0] suffix_length;
  logic cfg_write_enable = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Local copy of the registers and of the per-context statistics.
  logic [6:0] lim_reg = CODE_LIMIT_RESET;
  logic [7:0] halve_reg = HALVING_THRESHOLD_RESET;
  logic [4:0] esc_reg = ESCAPE_BITS_RESET;
  logic [7:0] init_sum_reg = INIT_ERROR_SUM[7:0];
  int err_acc [ALL_CONTEXTS];
  int bias_acc [ALL_CONTEXTS];
  int occ_count [ALL_CONTEXTS];
  int bias_corr [REGULAR_CONTEXTS];

  codeword_t pending_codes [$];
  int fail_count = 0;
  int stall_left = 0;
  bit steady = 1'b0;

  context_golomb_residual_coder #(
    .REGULAR_CONTEXTS(REGULAR_CONTEXTS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .context_index(context_index),
    .sign_negative(sign_negative),
    .prediction(prediction),
    .sample_value(sample_value),
    .left_neighbour(left_neighbour),
    .upper_neighbour(upper_neighbour),
    .run_type(run_type),
    .limit_reduction(limit_reduction),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .zero_count(zero_count),
    .suffix_bits(suffix_bits),
    .suffix_length(suffix_length),
    .cfg_write_enable(cfg_write_enable),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int idle_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Smallest k for which n shifted left by k reaches a, capped.
  function automatic int unsigned golomb_param(int n, int a);
    int unsigned k = 0;
    while ((longint'(n) << k) < longint'(a) && k < int'(K_MAX)) k++;
    return k;
  endfunction

  // Reduces an error into the range -128..127.
  function automatic int wrap_error(int e);
    if (e < 0) e += 256;
    if (e >= 128) e -= 256;
    return e;
  endfunction

  function automatic void accumulate_error(int q, int mag);
    int a;
    a = err_acc[q] + mag;
    err_acc[q] = (a > 65535) ? 65535 : a;
  endfunction

  // Halves the statistics once the count reaches the threshold, then counts the pixel.
  function automatic void age_context(int q);
    if (occ_count[q] >= int'(halve_reg)) begin
      occ_count[q] = occ_count[q] >> 1;
      err_acc[q] = err_acc[q] >> 1;
      bias_acc[q] = bias_acc[q] >>> 1;
    end
    occ_count[q]++;
  endfunction

  // Forms the limited-length Golomb codeword, escaping once the unary part reaches the limit.
  function automatic codeword_t pack_code(int m, int unsigned k, int lim);
    codeword_t c;
    bit [31:0] mu, unary, body, esc_w, len;
    mu = m;
    unary = mu >> k;
    esc_w = (esc_reg < 1) ? 1 : ((esc_reg > ESC_BITS_MAX) ? ESC_BITS_MAX : esc_reg);
    if (lim > 0 && unary < lim) begin
      c.zeros = unary[6:0];
      body = (32'd1 << k) + (mu & ((32'd1 << k) - 32'd1));
      len = k + 1;
    end else begin
      c.zeros = (lim > 0) ? lim[6:0] : 7'd0;
      body = (32'd1 << esc_w) + ((mu - 32'd1) & ((32'd1 << esc_w) - 32'd1));
      len = esc_w + 1;
    end
    c.suffix = body[15:0];
    c.length = len[4:0];
    return c;
  endfunction

  // Codes one pixel and updates the context statistics as the block does.
  function automatic codeword_t code_pixel(pixel_t p);
    int q, n, at, px, e, m, mag, b, sgn, rt, lim, extra;
    int unsigned k;
    bit flip;
    if (p.cmd == CMD_REGULAR) begin
      q = (p.ctx > REGULAR_CONTEXTS - 1) ? REGULAR_CONTEXTS - 1 : int'(p.ctx);
      sgn = p.sign_neg ? -1 : 1;
      n = occ_count[q];
      px = int'(p.pred) + sgn * bias_corr[q];
      if (px < 0) px = 0;
      else if (px > 255) px = 255;
      e = wrap_error(sgn * (int'(p.pixel) - px));
      k = golomb_param(n, err_acc[q]);
      flip = (k == 0) && (2 * bias_acc[q] <= -n);
      if (e < 0) begin
        mag = -e;
        m = 2 * mag - 1 - int'(flip);
      end else begin
        mag = e;
        m = 2 * e + int'(flip);
      end
      bias_acc[q] += e;
      accumulate_error(q, mag);
      age_context(q);
      // Bias correction follows the accumulated bias, one step per pixel.
      n = occ_count[q];
      b = bias_acc[q];
      if (b <= -n) begin
        if (bias_corr[q] > int'(CORR_MIN)) bias_corr[q]--;
        b += n;
        if (b <= -n) b = -n + 1;
      end else if (b > 0) begin
        if (bias_corr[q] < int'(CORR_MAX)) bias_corr[q]++;
        b -= n;
        if (b > 0) b = 0;
      end
      bias_acc[q] = b;
      lim = int'(lim_reg);
    end else begin
      rt = int'(p.rtype);
      q = REGULAR_CONTEXTS + rt;
      n = occ_count[q];
      at = err_acc[q];
      e = int'(p.pixel) - int'(p.upper_px);
      if (rt != 0) at += n >> 1;
      else if (p.upper_px < p.left_px) e = -e;
      k = golomb_param(n, at);
      e = wrap_error(e);
      extra = (k == 0 && e != 0 && 2 * bias_acc[q] < n) ? 1 : 0;
      if (e < 0) begin
        m = -2 * e - 1 - rt + extra;
        bias_acc[q]++;
      end else begin
        m = 2 * e - rt - extra;
      end
      // A zero error in the equal-neighbour context would map below zero.
      if (m < 0) m = 0;
      accumulate_error(q, (m + 1 - rt) >> 1);
      age_context(q);
      lim = int'(lim_reg) - int'(p.reduction);
    end
    return pack_code(m, k, lim);
  endfunction

  // Regular pixel; the fields the block ignores get random values.
  function automatic pixel_t make_regular(int ctx, bit neg, int pred, int pixel);
    pixel_t p;
    p.cmd = CMD_REGULAR;
    p.ctx = ctx[8:0];
    p.sign_neg = neg;
    p.pred = pred[7:0];
    p.pixel = pixel[7:0];
    p.left_px = 8'($urandom_range(0, 255));
    p.upper_px = 8'($urandom_range(0, 255));
    p.rtype = 1'($urandom_range(0, 1));
    p.reduction = 5'($urandom_range(0, 31));
    return p;
  endfunction

  function automatic pixel_t make_run(int pixel, int left_px, int upper_px, bit rt, int red);
    pixel_t p;
    p.cmd = CMD_RUN_INTERRUPTION;
    p.ctx = 9'($urandom_range(0, 511));
    p.sign_neg = 1'($urandom_range(0, 1));
    p.pred = 8'($urandom_range(0, 255));
    p.pixel = pixel[7:0];
    p.left_px = left_px[7:0];
    p.upper_px = upper_px[7:0];
    p.rtype = rt;
    p.reduction = red[4:0];
    return p;
  endfunction

  // Presents one item after a random gap and records its codeword once it is taken.
  task automatic send_pixel(pixel_t p);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= p.cmd;
    context_index <= p.ctx;
    sign_negative <= p.sign_neg;
    prediction <= p.pred;
    sample_value <= p.pixel;
    left_neighbour <= p.left_px;
    upper_neighbour <= p.upper_px;
    run_type <= p.rtype;
    limit_reduction <= p.reduction;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pending_codes.push_back(code_pixel(p));
  endtask

  // Stops sending and waits until every codeword is back and the context write-back is done.
  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all four registers once the block is idle.
  task automatic load_settings(int cl, int ht, int eb, int ies);
    quiesce();
    cfg_write_enable <= 1'b1;
    cfg_index <= CFG_CODE_LIMIT;
    cfg_data <= cl[7:0];
    @(posedge clk);
    lim_reg = cl[6:0];
    cfg_index <= CFG_HALVING_THRESHOLD;
    cfg_data <= ht[7:0];
    @(posedge clk);
    halve_reg = ht[7:0];
    cfg_index <= CFG_ESCAPE_BITS;
    cfg_data <= eb[7:0];
    @(posedge clk);
    esc_reg = eb[4:0];
    // The block ignores the initial error sum write, and there is no further reset.
    cfg_index <= CFG_INITIAL_ERROR_SUM;
    cfg_data <= ies[7:0];
    @(posedge clk);
    init_sum_reg = ies[7:0];
    cfg_write_enable <= 1'b0;
  endtask

  // Random pixels: mostly small errors on a few busy contexts, with a drift that moves the
  // bias correction, plus well-formed run interruptions and some noise.
  task automatic run_random(int count);
    pixel_t p;
    int drift, err, ctx, r, base, rt, red;
    drift = $urandom_range(0, 40) - 20;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          ctx = $urandom_range(0, 3);
          if (ctx == 3) ctx = REGULAR_CONTEXTS - 1;
        end else if (r < 90) begin
          ctx = $urandom_range(0, REGULAR_CONTEXTS - 1);
        end else begin
          ctx = $urandom_range(REGULAR_CONTEXTS, 511);
        end
        r = $urandom_range(0, 99);
        if (r < 60) err = drift + $urandom_range(0, 6) - 3;
        else if (r < 85) err = $urandom_range(0, 64) - 32;
        else err = $urandom_range(0, 255);
        base = $urandom_range(0, 255);
        p = make_regular(ctx, 1'($urandom_range(0, 1)), base, base + err);
      end else begin
        base = $urandom_range(0, 255);
        rt = $urandom_range(0, 1);
        r = $urandom_range(0, 99);
        if (r < 30) err = 0;
        else if (r < 85) err = $urandom_range(0, 16) - 8;
        else err = $urandom_range(0, 255);
        red = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 8);
        if ($urandom_range(0, 4) != 0) begin
          // Well formed: equal neighbours select the second run context.
          p = make_run(base + err, rt ? base : base + $urandom_range(1, 40) * (rt ? 1 : -1),
                       base, 1'(rt), red);
          if (!rt && $urandom_range(0, 1)) p.left_px = 8'(base + $urandom_range(1, 40));
        end else begin
          p = make_run(base + err, $urandom_range(0, 255), base, 1'(rt), red);
        end
      end
      send_pixel(p);
    end
  endtask

  // Field extremes, out-of-range contexts, both run contexts and the zero-error case.
  task automatic test_field_extremes();
    send_pixel(make_regular(0, 1'b0, 0, 255));
    send_pixel(make_regular(REGULAR_CONTEXTS - 1, 1'b1, 255, 0));
    send_pixel(make_regular(511, 1'b0, 128, 128));
    send_pixel(make_regular(REGULAR_CONTEXTS, 1'b1, 127, 128));
    send_pixel(make_regular(0, 1'b0, 255, 255));
    send_pixel(make_regular(256, 1'b1, 100, 228));
    send_pixel(make_run(100, 100, 100, 1'b1, 0));
    send_pixel(make_run(0, 200, 255, 1'b0, 0));
    send_pixel(make_run(255, 255, 0, 1'b0, 31));
    send_pixel(make_run(0, 0, 255, 1'b1, 31));
    send_pixel(make_run(128, 10, 10, 1'b1, 5));
  endtask

  // Escape codes: seventeen-bit suffix, clamped escape widths and negative run limits.
  task automatic test_escape_codes();
    load_settings(2, 2, 16, 255);
    send_pixel(make_regular(0, 1'b0, 0, 127));
    send_pixel(make_regular(1, 1'b1, 200, 72));
    send_pixel(make_regular(2, 1'b0, 50, 50));
    send_pixel(make_run(0, 0, 128, 1'b0, 31));
    send_pixel(make_run(100, 100, 100, 1'b1, 31));
    send_pixel(make_run(0, 50, 50, 1'b1, 1));
    load_settings(2, 2, 0, 1);
    send_pixel(make_regular(3, 1'b0, 10, 200));
    send_pixel(make_run(77, 20, 20, 1'b1, 0));
    load_settings(2, 2, 31, 1);
    send_pixel(make_regular(4, 1'b1, 10, 200));
    send_pixel(make_run(200, 30, 30, 1'b1, 0));
  endtask

  task automatic test_random_reset_settings();
    load_settings(int'(CODE_LIMIT_RESET), int'(HALVING_THRESHOLD_RESET),
                  int'(ESCAPE_BITS_RESET), int'(INIT_ERROR_SUM));
    run_random(360);
  endtask

  task automatic test_random_wide_codes();
    load_settings(64, 255, 16, 1);
    run_random(400);
  endtask

  task automatic test_random_tight_codes();
    load_settings(2, 2, 1, 255);
    run_random(280);
  endtask

  task automatic test_random_mixed_settings();
    repeat (2) begin
      load_settings($urandom_range(2, 64), $urandom_range(2, 255), $urandom_range(1, 16),
                    $urandom_range(1, 255));
      run_random(150);
    end
  endtask

  // Full rate on both sides with no idling at all.
  task automatic test_back_to_back();
    load_settings(16, 32, 12, 128);
    steady = 1'b1;
    run_random(250);
    steady = 1'b0;
  endtask

  task automatic flag_field(string name, int want, int got);
    if (fail_count < REPORT_LIMIT)
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
    fail_count++;
  endtask

  // Compares each codeword taken with the oldest one predicted, and drives the receiver stall.
  always @(posedge clk) begin : check_codes
    codeword_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_codes.size() == 0) begin
        if (fail_count < REPORT_LIMIT)
          $display("%0t ns: codeword with none expected, zero_count %0d suffix_bits %0d",
                   $time, zero_count, suffix_bits);
        fail_count++;
      end else begin
        want = pending_codes.pop_front();
        if (zero_count !== want.zeros)
          flag_field("zero_count", int'(want.zeros), int'(zero_count));
        if (suffix_bits !== want.suffix)
          flag_field("suffix_bits", int'(want.suffix), int'(suffix_bits));
        if (suffix_length !== want.length)
          flag_field("suffix_length", int'(want.length), int'(suffix_length));
      end
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 3) == 0) stall_left = idle_len();
    end
  end

  // Statistics after reset, then the test sequence.
  initial begin
    for (int i = 0; i < ALL_CONTEXTS; i++) begin
      err_acc[i] = int'(INIT_ERROR_SUM);
      bias_acc[i] = 0;
      occ_count[i] = int'(INIT_OCCURRENCE);
    end
    for (int i = 0; i < REGULAR_CONTEXTS; i++) bias_corr[i] = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_field_extremes();
    test_escape_codes();
    test_random_reset_settings();
    test_random_wide_codes();
    test_random_tight_codes();
    test_random_mixed_settings();
    test_back_to_back();
    quiesce();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #8_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
